[rtl/ehx_pkg.sv]
package ehx_pkg;

   // frame layout, byte positions from the first byte of the frame
   localparam logic [15:0] MAC_DST_END   = 16'd6;
   localparam logic [15:0] MAC_SRC_END   = 16'd12;
   localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
   localparam logic [15:0] IHL_POS       = 16'd14;
   localparam logic [15:0] PROTO_POS     = 16'd23;
   localparam logic [15:0] IP_FIRST      = 16'd26;
   localparam logic [15:0] IP_END        = 16'd34;
   localparam logic [5:0]  IP_LAST       = 6'd33;
   localparam logic [15:0] PORT_BYTES    = 16'd4;
   localparam logic [15:0] FLAG_OFFSET   = 16'd13;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   typedef enum logic [1:0] {
      FRAME_SHORT = 2'd0,
      FRAME_OTHER = 2'd1,
      FRAME_IPV4  = 2'd2
   } frame_status_type;

   // one input word
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [63:0] arrival_time;
   } in_word_type;

   // one result word
   typedef struct packed {
      frame_status_type frame_status;
      logic [47:0]      dst_mac;
      logic [47:0]      src_mac;
      logic [31:0]      src_ip;
      logic [31:0]      dst_ip;
      logic [7:0]       ip_protocol;
      logic [15:0]      frame_length;
      logic [15:0]      src_port;
      logic [15:0]      dst_port;
      logic [3:0]       tcp_flags;
      logic [63:0]      frame_time;
      logic [5:0]       header_len_bytes;
   } result_type;

   // tcp flag byte to bit0 syn, bit1 ack, bit2 fin, bit3 rst
   function automatic logic [3:0] map_flags(input logic [7:0] b);
      map_flags = {b[2], b[0], b[4], b[1]};
   endfunction

endpackage

[rtl/eth_ipv4_l4_header_extractor_core.sv]
// Ethernet/IPv4 header extractor: takes one frame byte per cycle on the req_ channel and gives
// one result word on the rsp_ channel for the byte marked last, with both MACs, the ethertype
// status, IPv4 addresses, protocol, saturating length, TCP/UDP ports, TCP flags, the time
// sampled on the first byte and the IPv4 header length. A byte can be accepted every cycle;
// it is held in the input register and parsed into the output register, which drives
// rsp_valid. The block stalls only when a last byte meets a result register still held by
// rsp_ready low.
module eth_ipv4_l4_header_extractor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [63:0] req_arrival_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [47:0] rsp_dst_mac,
   output logic [47:0] rsp_src_mac,
   output logic [31:0] rsp_src_ip,
   output logic [31:0] rsp_dst_ip,
   output logic [7:0]  rsp_ip_protocol,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [3:0]  rsp_tcp_flags,
   output logic [63:0] rsp_frame_time,
   output logic [5:0]  rsp_header_len_bytes
);
   import ehx_pkg::*;

   in_word_type req_word;
   in_word_type word;
   logic        word_valid;
   logic        consume;
   logic        out_free;
   result_type  result;
   result_type  rsp_word;

   assign req_word.data_byte    = req_data_byte;
   assign req_word.last_byte    = req_last_byte;
   assign req_word.arrival_time = req_arrival_time;

   // a word moves on unless it closes a frame and the result slot is full
   assign consume = word_valid && (!word.last_byte || out_free);

   ehx_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .consume    (consume),
      .word_valid (word_valid),
      .word       (word)
   );

   ehx_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .consume (consume),
      .word    (word),
      .result  (result)
   );

   ehx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && word.last_byte),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_frame_status     = rsp_word.frame_status;
   assign rsp_dst_mac          = rsp_word.dst_mac;
   assign rsp_src_mac          = rsp_word.src_mac;
   assign rsp_src_ip           = rsp_word.src_ip;
   assign rsp_dst_ip           = rsp_word.dst_ip;
   assign rsp_ip_protocol      = rsp_word.ip_protocol;
   assign rsp_frame_length     = rsp_word.frame_length;
   assign rsp_src_port         = rsp_word.src_port;
   assign rsp_dst_port         = rsp_word.dst_port;
   assign rsp_tcp_flags        = rsp_word.tcp_flags;
   assign rsp_frame_time       = rsp_word.frame_time;
   assign rsp_header_len_bytes = rsp_word.header_len_bytes;

endmodule

[rtl/ehx_in_reg.sv]
module ehx_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ehx_pkg::in_word_type req_word,
   input  logic                consume,
   output logic                word_valid,
   output ehx_pkg::in_word_type word
);
   import ehx_pkg::*;

   logic        valid_ff, valid_in;
   in_word_type word_ff;
   logic        load;

   // take a new word when empty or when the held word moves on
   assign req_ready = !valid_ff || consume;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

[rtl/ehx_parse.sv]
module ehx_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 consume,
   input  ehx_pkg::in_word_type word,
   output ehx_pkg::result_type  result
);
   import ehx_pkg::*;

   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [3:0]  ihl_words_ff, ihl_words_in;
   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [63:0] ip_pair_ff, ip_pair_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] port_pair_ff, port_pair_in;
   logic [3:0]  flag_bits_ff, flag_bits_in;
   logic [63:0] time_ff, time_in;

   logic        first;
   logic [15:0] idx;
   logic [15:0] count;
   logic [15:0] tstart;
   logic [15:0] toff;
   logic [5:0]  ip_sel;
   logic [7:0]  b;

   assign b     = word.data_byte;
   assign idx   = byte_index_ff;
   assign first = (byte_index_ff == 16'd0);
   assign count = (idx == COUNT_MAX) ? COUNT_MAX : idx + 16'd1;

   // capture of header fields for the current byte
   always_comb begin
      ether_type_in = first ? 16'd0 : ether_type_ff;
      ihl_words_in  = first ? 4'd0  : ihl_words_ff;
      dst_mac_in    = first ? 48'd0 : dst_mac_ff;
      src_mac_in    = first ? 48'd0 : src_mac_ff;
      ip_pair_in    = first ? 64'd0 : ip_pair_ff;
      proto_in      = first ? 8'd0  : proto_ff;
      port_pair_in  = first ? 32'd0 : port_pair_ff;
      flag_bits_in  = first ? 4'd0  : flag_bits_ff;
      time_in       = first ? word.arrival_time : time_ff;
      ip_sel        = IP_LAST - idx[5:0];

      if (idx < MAC_DST_END) begin
         dst_mac_in = {dst_mac_in[39:0], b};
      end else if (idx < MAC_SRC_END) begin
         src_mac_in = {src_mac_in[39:0], b};
      end else if (idx < ETH_HDR_BYTES) begin
         ether_type_in = {ether_type_in[7:0], b};
      end else if (idx == IHL_POS) begin
         ihl_words_in = b[3:0];
      end else if (idx == PROTO_POS) begin
         proto_in = b;
      end else if (idx >= IP_FIRST && idx < IP_END) begin
         ip_pair_in[{ip_sel[2:0], 3'b000} +: 8] = b;
      end

      // transport header follows the ip header length just seen
      tstart = ETH_HDR_BYTES + {10'd0, ihl_words_in, 2'b00};
      toff   = idx - tstart;
      if (idx >= tstart && toff < PORT_BYTES) begin
         port_pair_in[{~toff[1:0], 3'b000} +: 8] = b;
      end
      if (idx == tstart + FLAG_OFFSET) begin
         flag_bits_in = map_flags(b);
      end

      byte_index_in = word.last_byte ? 16'd0 : count;
   end

   // result for a frame ending on this byte
   always_comb begin
      result = '0;
      result.frame_status = FRAME_SHORT;
      if (count >= ETH_HDR_BYTES) begin
         result.dst_mac = dst_mac_in;
         result.src_mac = src_mac_in;
         if (ether_type_in != ETHERTYPE_IPV4) begin
            result.frame_status = FRAME_OTHER;
         end else begin
            result.frame_status     = FRAME_IPV4;
            result.src_ip           = ip_pair_in[63:32];
            result.dst_ip           = ip_pair_in[31:0];
            result.ip_protocol      = proto_in;
            result.frame_length     = count;
            result.frame_time       = time_in;
            result.header_len_bytes = {ihl_words_in, 2'b00};
            if (proto_in == PROTO_TCP || proto_in == PROTO_UDP) begin
               result.src_port = port_pair_in[31:16];
               result.dst_port = port_pair_in[15:0];
            end
            if (proto_in == PROTO_TCP) begin
               result.tcp_flags = flag_bits_in;
            end
         end
      end
   end

   // byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 16'd0;
      end else if (consume) begin
         byte_index_ff <= byte_index_in;
      end
   end

   // capture registers, cleared on the first byte of each frame
   always_ff @(posedge clock) begin
      if (consume) begin
         ether_type_ff <= ether_type_in;
         ihl_words_ff  <= ihl_words_in;
         dst_mac_ff    <= dst_mac_in;
         src_mac_ff    <= src_mac_in;
         ip_pair_ff    <= ip_pair_in;
         proto_ff      <= proto_in;
         port_pair_ff  <= port_pair_in;
         flag_bits_ff  <= flag_bits_in;
         time_ff       <= time_in;
      end
   end

endmodule

[rtl/ehx_out_reg.sv]
module ehx_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ehx_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ehx_pkg::result_type rsp_word
);
   import ehx_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // room for a new result when empty or when the held one leaves now
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = result_ff;

endmodule

[tb/sv/eth_ipv4_l4_header_extractor_core_tb.sv]
`timescale 1ns / 100ps

module eth_ipv4_l4_header_extractor_core_tb;

   import ehx_pkg::*;

   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] ETHERTYPE_NEAR = 16'h0801;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam int          IDLE_PCT       = 16;
   localparam int          LONG_HOLD      = 400;

   typedef struct {
      in_word_type word;
      bit          hold;
   } pending_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic [63:0] req_arrival_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_status;
   logic [47:0] rsp_dst_mac;
   logic [47:0] rsp_src_mac;
   logic [31:0] rsp_src_ip;
   logic [31:0] rsp_dst_ip;
   logic [7:0]  rsp_ip_protocol;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_src_port;
   logic [15:0] rsp_dst_port;
   logic [3:0]  rsp_tcp_flags;
   logic [63:0] rsp_frame_time;
   logic [5:0]  rsp_header_len_bytes;

   eth_ipv4_l4_header_extractor_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .req_arrival_time     (req_arrival_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_dst_mac          (rsp_dst_mac),
      .rsp_src_mac          (rsp_src_mac),
      .rsp_src_ip           (rsp_src_ip),
      .rsp_dst_ip           (rsp_dst_ip),
      .rsp_ip_protocol      (rsp_ip_protocol),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_src_port         (rsp_src_port),
      .rsp_dst_port         (rsp_dst_port),
      .rsp_tcp_flags        (rsp_tcp_flags),
      .rsp_frame_time       (rsp_frame_time),
      .rsp_header_len_bytes (rsp_header_len_bytes)
   );

   always #5 clock = ~clock;

   // bookkeeping shared between driver, monitor and sequencer
   pending_byte_type pending[$];
   pending_byte_type next_word;
   result_type    headers_due[$];
   result_type    want_hdr;
   logic [7:0]    frame_bytes[$];
   int            bytes_planned = 0;
   int            bytes_taken = 0;
   int            frames_done = 0;
   int            results_seen = 0;
   int            mismatch_count = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   logic          calm_window;

   // parser shadow state
   logic [15:0] pos_count = '0;
   logic [47:0] dmac_acc = '0;
   logic [47:0] smac_acc = '0;
   logic [15:0] etype_acc = '0;
   logic [3:0]  ihl_acc = '0;
   logic [63:0] ip_acc = '0;
   logic [7:0]  proto_acc = '0;
   logic [31:0] ports_acc = '0;
   logic [3:0]  flags_acc = '0;
   logic [63:0] stamp_acc = '0;

   // no idling on either side through a band of results
   assign calm_window = (results_seen >= 28) && (results_seen < 40);

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("result %0d field %s: got %h want %h", results_seen, what, got, want);
   endtask

   // shadow parser: take one byte, queue the header word on the last byte
   task automatic parse_byte(input in_word_type w);
      int         idx;
      int         t0;
      int         count;
      result_type r;
      if (pos_count == 0) begin
         dmac_acc  = '0;
         smac_acc  = '0;
         etype_acc = '0;
         ihl_acc   = '0;
         ip_acc    = '0;
         proto_acc = '0;
         ports_acc = '0;
         flags_acc = '0;
         stamp_acc = w.arrival_time;
      end
      idx = pos_count;

      // ethernet and ip header captures
      if (idx < MAC_DST_END) begin
         dmac_acc = {dmac_acc[39:0], w.data_byte};
      end else if (idx < MAC_SRC_END) begin
         smac_acc = {smac_acc[39:0], w.data_byte};
      end else if (idx < ETH_HDR_BYTES) begin
         etype_acc = {etype_acc[7:0], w.data_byte};
      end else if (idx == IHL_POS) begin
         ihl_acc = w.data_byte[3:0];
      end else if (idx == PROTO_POS) begin
         proto_acc = w.data_byte;
      end else if (idx >= IP_FIRST && idx < IP_END) begin
         ip_acc[8 * (int'(IP_LAST) - idx) +: 8] = w.data_byte;
      end

      // transport header, placed by the header length seen so far
      t0 = int'(ETH_HDR_BYTES) + 4 * int'(ihl_acc);
      if (idx >= t0 && idx < t0 + int'(PORT_BYTES))
         ports_acc[8 * (3 - (idx - t0)) +: 8] = w.data_byte;
      if (idx == t0 + int'(FLAG_OFFSET)) begin
         flags_acc[0] = w.data_byte[1];   // syn
         flags_acc[1] = w.data_byte[4];   // ack
         flags_acc[2] = w.data_byte[0];   // fin
         flags_acc[3] = w.data_byte[2];   // rst
      end

      count = (idx < int'(COUNT_MAX)) ? idx + 1 : int'(COUNT_MAX);
      pos_count = count[15:0];

      // header word for the finished frame
      if (w.last_byte) begin
         r = '0;
         r.frame_status = FRAME_SHORT;
         if (count >= int'(ETH_HDR_BYTES)) begin
            r.dst_mac = dmac_acc;
            r.src_mac = smac_acc;
            if (etype_acc != ETHERTYPE_IPV4) begin
               r.frame_status = FRAME_OTHER;
            end else begin
               r.frame_status     = FRAME_IPV4;
               r.src_ip           = ip_acc[63:32];
               r.dst_ip           = ip_acc[31:0];
               r.ip_protocol      = proto_acc;
               r.frame_length     = count[15:0];
               r.frame_time       = stamp_acc;
               r.header_len_bytes = {ihl_acc, 2'b00};
               if (proto_acc == PROTO_TCP || proto_acc == PROTO_UDP) begin
                  r.src_port = ports_acc[31:16];
                  r.dst_port = ports_acc[15:0];
               end
               if (proto_acc == PROTO_TCP)
                  r.tcp_flags = flags_acc;
            end
         end
         headers_due.push_back(r);
         pos_count = '0;
      end
   endtask

   // random frame body with ethertype, header length nibble and protocol placed
   task automatic make_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto);
      logic [3:0] ver;
      frame_bytes.delete();
      for (int i = 0; i < len; i++)
         frame_bytes.push_back(8'($urandom_range(0, 255)));
      ver = 4'($urandom_range(0, 15));
      if (len > 13) begin
         frame_bytes[12] = etype[15:8];
         frame_bytes[13] = etype[7:0];
      end
      if (len > 14)
         frame_bytes[14] = {ver, ihl};
      if (len > 23)
         frame_bytes[23] = proto;
   endtask

   // move the built frame into the driver queue
   task automatic push_frame(input logic [63:0] stamp, input bit hold);
      pending_byte_type p;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         p.word.data_byte    = frame_bytes[i];
         p.word.last_byte    = (i == frame_bytes.size() - 1);
         p.word.arrival_time = (i == 0) ? stamp : {$urandom, $urandom};
         p.hold              = hold && (i == 0);
         pending.push_back(p);
      end
      bytes_planned += frame_bytes.size();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // word taken at this edge
         if (req_valid && req_ready) begin
            parse_byte({req_data_byte, req_last_byte, req_arrival_time});
            bytes_taken <= bytes_taken + 1;
            if (req_last_byte)
               frames_done <= frames_done + 1;
         end
         // offer the next word or idle
         if (!req_valid || req_ready) begin
            if (pending.size() != 0 && (calm_window || $urandom_range(0, 99) >= IDLE_PCT)
                && (!pending[0].hold || (!req_valid && results_seen == frames_done))) begin
               next_word = pending.pop_front();
               req_data_byte    <= next_word.word.data_byte;
               req_last_byte    <= next_word.word.last_byte;
               req_arrival_time <= next_word.word.arrival_time;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 25) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm_window || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (results_seen >= frames_done) begin
            flag_mismatch("unexpected word", '0, '0);
         end else begin
            want_hdr = headers_due.pop_front();
            if (rsp_frame_status !== want_hdr.frame_status)
               flag_mismatch("frame_status", rsp_frame_status, want_hdr.frame_status);
            if (rsp_dst_mac !== want_hdr.dst_mac)
               flag_mismatch("dst_mac", rsp_dst_mac, want_hdr.dst_mac);
            if (rsp_src_mac !== want_hdr.src_mac)
               flag_mismatch("src_mac", rsp_src_mac, want_hdr.src_mac);
            if (rsp_src_ip !== want_hdr.src_ip)
               flag_mismatch("src_ip", rsp_src_ip, want_hdr.src_ip);
            if (rsp_dst_ip !== want_hdr.dst_ip)
               flag_mismatch("dst_ip", rsp_dst_ip, want_hdr.dst_ip);
            if (rsp_ip_protocol !== want_hdr.ip_protocol)
               flag_mismatch("ip_protocol", rsp_ip_protocol, want_hdr.ip_protocol);
            if (rsp_frame_length !== want_hdr.frame_length)
               flag_mismatch("frame_length", rsp_frame_length, want_hdr.frame_length);
            if (rsp_src_port !== want_hdr.src_port)
               flag_mismatch("src_port", rsp_src_port, want_hdr.src_port);
            if (rsp_dst_port !== want_hdr.dst_port)
               flag_mismatch("dst_port", rsp_dst_port, want_hdr.dst_port);
            if (rsp_tcp_flags !== want_hdr.tcp_flags)
               flag_mismatch("tcp_flags", rsp_tcp_flags, want_hdr.tcp_flags);
            if (rsp_frame_time !== want_hdr.frame_time)
               flag_mismatch("frame_time", rsp_frame_time, want_hdr.frame_time);
            if (rsp_header_len_bytes !== want_hdr.header_len_bytes)
               flag_mismatch("header_len_bytes", rsp_header_len_bytes,
                             want_hdr.header_len_bytes);
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("eth_ipv4_l4_header_extractor_core: mismatch");
      $finish;
   end

   // frame sequence, reset and end of run
   initial begin
      int          len;
      int          t0;
      int          kind;
      int          rand_bytes;
      int          rand_frames;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [15:0] etype;

      // single byte and thirteen byte frames are too short for a header
      frame_bytes = {8'hFF};
      push_frame('1, 1'b0);
      frame_bytes.delete();
      for (int i = 0; i < 13; i++)
         frame_bytes.push_back(8'h00);
      push_frame('0, 1'b0);

      // ipv4 ethertype with nothing after the ethernet header
      make_frame(14, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);

      // non-ipv4: ipv6, a near miss, and a frame of all ones
      make_frame(14, ETHERTYPE_IPV6, 4'd5, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(60, ETHERTYPE_NEAR, 4'd5, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);
      frame_bytes.delete();
      for (int i = 0; i < 60; i++)
         frame_bytes.push_back(8'hFF);
      push_frame('1, 1'b0);

      // tcp with every flag, no flags, all flag bits
      make_frame(60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      frame_bytes[47] = 8'h17;
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      frame_bytes[47] = 8'h00;
      push_frame('0, 1'b0);
      make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      frame_bytes[47] = 8'hFF;
      push_frame('1, 1'b0);

      // udp, and a protocol with no ports
      make_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP);
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(60, ETHERTYPE_IPV4, 4'd5, PROTO_ICMP);
      push_frame({$urandom, $urandom}, 1'b0);

      // header length zero: the ihl byte is also the first port byte
      make_frame(40, ETHERTYPE_IPV4, 4'd0, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);
      // small header length: ports overlap the protocol byte
      make_frame(50, ETHERTYPE_IPV4, 4'd2, PROTO_UDP);
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(40, ETHERTYPE_IPV4, 4'd2, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);
      // largest header length
      make_frame(90, ETHERTYPE_IPV4, 4'd15, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);

      // frames ending inside the addresses, the ports and before the flags
      make_frame(30, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(36, ETHERTYPE_IPV4, 4'd5, PROTO_UDP);
      push_frame({$urandom, $urandom}, 1'b0);
      make_frame(40, ETHERTYPE_IPV4, 4'd5, PROTO_TCP);
      push_frame({$urandom, $urandom}, 1'b0);

      // random traffic, mostly well-formed ipv4
      rand_bytes  = 0;
      rand_frames = 0;
      while (rand_bytes < 1090) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            ihl = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom_range(0, 15));
            kind = $urandom_range(0, 99);
            if (kind < 45)
               proto = PROTO_TCP;
            else if (kind < 85)
               proto = PROTO_UDP;
            else
               proto = 8'($urandom_range(0, 255));
            t0 = int'(ETH_HDR_BYTES) + 4 * int'(ihl);
            if ($urandom_range(0, 9) == 0)
               len = $urandom_range(14, t0 + 14);
            else
               len = t0 + $urandom_range(10, 20);
            etype = ETHERTYPE_IPV4;
         end else if (kind < 85) begin
            len   = $urandom_range(14, 64);
            etype = 16'($urandom_range(0, 65535));
            ihl   = 4'($urandom_range(0, 15));
            proto = 8'($urandom_range(0, 255));
         end else begin
            len   = $urandom_range(1, 13);
            etype = ETHERTYPE_IPV4;
            ihl   = 4'd5;
            proto = PROTO_TCP;
         end
         make_frame(len, etype, ihl, proto);
         push_frame({$urandom, $urandom}, rand_frames == 0 || $urandom_range(0, 24) == 0);
         rand_bytes  += len;
         rand_frames += 1;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (bytes_taken != bytes_planned)
         @(posedge clock);
      while (results_seen != frames_done)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("eth_ipv4_l4_header_extractor_core: match");
      else
         $display("eth_ipv4_l4_header_extractor_core: mismatch");
      $finish;
   end

endmodule
